// ----- sv/text_console_char_handler_core_macros.svh -----
// ---------------------------------------------------------------------------
// Text console assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_HANDLER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CHAR_HANDLER_CORE_MACROS_SVH

// Checked only out of reset
`define TCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included
`define TCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/tcc_pkg.sv -----
// ---------------------------------------------------------------------------
// Text console package
// Geometry, field widths, character codes, register indexes and FSM states.
// ---------------------------------------------------------------------------
package tcc_pkg;

    // Screen geometry
    localparam int unsigned COLS   = 80;
    localparam int unsigned ROWS   = 25;
    localparam int unsigned CELLS  = COLS * ROWS;
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned ROW_W  = $clog2(ROWS);
    localparam int unsigned COL_W  = $clog2(COLS);

    // Field widths
    localparam int unsigned OP_W       = 1;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned IDX_W      = 11;
    localparam int unsigned ROW_OUT_W  = 5;
    localparam int unsigned COL_OUT_W  = 7;
    localparam int unsigned CELL_W     = 16;
    localparam int unsigned TXT_W      = 4;
    localparam int unsigned BCK_W      = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;

    // Cell and cursor constants
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
    localparam int unsigned       TAB_STEP   = 8;
    localparam logic [TXT_W-1:0]  TXT_RESET  = 4'd15;
    localparam logic [BCK_W-1:0]  BCK_RESET  = 3'd0;

    // Operations
    localparam logic [OP_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOUR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOUR = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILL,
        S_BLANK,
        S_RDWAIT,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ----- sv/tcc_if.sv -----
// ---------------------------------------------------------------------------
// Text console channel interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface tcc_req_if;
    logic                             valid;
    logic                             ready;
    logic [tcc_pkg::OP_W-1:0]         op;
    logic [tcc_pkg::CHAR_W-1:0]       char_code;
    logic [tcc_pkg::IDX_W-1:0]        cell_index;

    modport source (output valid, op, char_code, cell_index, input ready);
    modport sink   (input valid, op, char_code, cell_index, output ready);
endinterface

interface tcc_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [tcc_pkg::ROW_OUT_W-1:0]    cursor_row;
    logic [tcc_pkg::COL_OUT_W-1:0]    cursor_col;
    logic [tcc_pkg::CELL_W-1:0]       cell_value;

    modport source (output valid, cursor_row, cursor_col, cell_value, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_value, output ready);
endinterface

// ----- sv/tcc_cell_ram.sv -----
// ---------------------------------------------------------------------------
// Text console cell RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tcc_cell_ram #(
    parameter int unsigned DEPTH = 2000,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/text_console_char_handler_core.sv -----
// ---------------------------------------------------------------------------
// Text console character handler
// Cell store, cursor and a small sequencer driving one address adder.
// ---------------------------------------------------------------------------
// Takes one item at a time; ready is high only while the sequencer is idle.
// Steps per item from accept: read RDWAIT, DONE; control byte DONE; printable
// byte WRITE, DONE; at column 0 BLANK first (the row is blanked one cell per
// cycle); form feed FILL (whole screen, one cell per cycle), DONE. DONE waits
// for a free output register. The cell RAM has one write port. After reset
// the block runs a clearing pass over all COLS*ROWS cells (2000 at 80x25)
// before ready rises; configuration writes are taken during it. A finished
// result waits in the output register while the next item is accepted.
`include "text_console_char_handler_core_macros.svh"

module text_console_char_handler_core (
    input  logic                            clk,
    input  logic                            rst_n,
    tcc_req_if.sink                         req,
    tcc_rsp_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned ADDR_W = tcc_pkg::ADDR_W;
    localparam int unsigned ROW_W  = tcc_pkg::ROW_W;
    localparam int unsigned COL_W  = tcc_pkg::COL_W;
    localparam int unsigned CELL_W = tcc_pkg::CELL_W;

    tcc_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]               addr_reg, addr_next;
    logic [ADDR_W-1:0]               last_reg, last_next;
    logic [CELL_W-1:0]               fill_reg, fill_next;
    logic [ROW_W-1:0]                row_reg, row_next;
    logic [COL_W-1:0]                col_reg, col_next;
    logic [ADDR_W-1:0]               base_reg, base_next;
    logic [tcc_pkg::TXT_W-1:0]       text_colour_reg, text_colour_next;
    logic [tcc_pkg::BCK_W-1:0]       back_colour_reg, back_colour_next;
    logic                            out_valid_reg, out_valid_next;

    logic [tcc_pkg::CHAR_W-1:0]      char_reg, char_next;
    logic                            idx_ok_reg, idx_ok_next;
    logic [CELL_W-1:0]               val_reg, val_next;
    logic [tcc_pkg::ROW_OUT_W-1:0]   out_row_reg, out_row_next;
    logic [tcc_pkg::COL_OUT_W-1:0]   out_col_reg, out_col_next;
    logic [CELL_W-1:0]               out_val_reg, out_val_next;

    // Shared address adder
    logic [ADDR_W-1:0]               add_a;
    logic [ADDR_W-1:0]               add_b;
    logic [ADDR_W-1:0]               add_sum;

    // Cell RAM port
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [CELL_W-1:0]               ram_wdata;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [CELL_W-1:0]               ram_rdata;

    // Tab stop
    logic [COL_W:0]                  tab_sum;
    logic [COL_W:0]                  tab_stop;
    logic [COL_W-1:0]                tab_col;

    logic                            col_zero;
    logic                            col_last;
    logic                            row_last;
    logic                            sweep_end;
    logic [CELL_W-1:0]               put_cell;

    // Assertion terms
    logic                            cursor_ok;
    logic                            sweep_ok;

    tcc_cell_ram #(
        .DEPTH (tcc_pkg::CELLS),
        .WIDTH (CELL_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Cursor tests and tab stop
    assign col_zero  = (col_reg == '0);
    assign col_last  = (col_reg == COL_W'(tcc_pkg::COLS - 1));
    assign row_last  = (row_reg == ROW_W'(tcc_pkg::ROWS - 1));
    assign sweep_end = (addr_reg == last_reg);
    assign tab_sum   = {1'b0, col_reg} + (COL_W+1)'(tcc_pkg::TAB_STEP);
    assign tab_stop  = tab_sum & ~((COL_W+1)'(tcc_pkg::TAB_STEP - 1));
    assign tab_col   = (tab_stop >= (COL_W+1)'(tcc_pkg::COLS))
                     ? COL_W'(tcc_pkg::COLS - 1) : tab_stop[COL_W-1:0];
    assign put_cell  = CELL_W'({1'b0, back_colour_reg, text_colour_reg, char_reg});

    // Adder operand select
    always_comb
    begin
        add_a = base_reg;
        add_b = '0;
        unique case (state_reg) inside
            tcc_pkg::S_IDLE:
            begin
                if (req.char_code == tcc_pkg::CH_LF)
                begin
                    add_b = ADDR_W'(tcc_pkg::COLS);
                end
                else if (col_zero)
                begin
                    add_b = ADDR_W'(tcc_pkg::COLS - 1);
                end
                else
                begin
                    add_b = ADDR_W'(col_reg);
                end
            end
            tcc_pkg::S_CLEAR, tcc_pkg::S_FILL, tcc_pkg::S_BLANK:
            begin
                add_a = addr_reg;
                add_b = ADDR_W'(1);
            end
            tcc_pkg::S_WRITE:
            begin
                add_b = ADDR_W'(tcc_pkg::COLS);
            end
            default:
            begin
                add_b = '0;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    assign req.ready      = (state_reg == tcc_pkg::S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cell_value = out_val_reg;

    // Configuration registers
    always_comb
    begin
        text_colour_next = text_colour_reg;
        back_colour_next = back_colour_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tcc_pkg::CFG_TEXT_COLOUR: text_colour_next = cfg_data[tcc_pkg::TXT_W-1:0];
                tcc_pkg::CFG_BACK_COLOUR: back_colour_next = cfg_data[tcc_pkg::BCK_W-1:0];
                default:                  text_colour_next = text_colour_reg;
            endcase
        end
    end

    // Sequencer next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        char_next      = char_reg;
        idx_ok_next    = idx_ok_reg;
        val_next       = val_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = fill_reg;
        ram_raddr      = ADDR_W'(req.cell_index);

        unique case (state_reg)
            tcc_pkg::S_CLEAR:
            begin
                ram_we = 1'b1;
                if (sweep_end)
                begin
                    state_next = tcc_pkg::S_IDLE;
                end
                else
                begin
                    addr_next = add_sum;
                end
            end

            tcc_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == tcc_pkg::OP_READ)
                    begin
                        idx_ok_next = (32'(req.cell_index) < 32'(tcc_pkg::CELLS));
                        state_next  = tcc_pkg::S_RDWAIT;
                    end
                    else
                    begin
                        val_next   = '0;
                        state_next = tcc_pkg::S_DONE;
                        unique case (req.char_code)
                            tcc_pkg::CH_BS:
                            begin
                                if (!col_zero)
                                begin
                                    col_next = col_reg - COL_W'(1);
                                end
                            end
                            tcc_pkg::CH_TAB:
                            begin
                                col_next = tab_col;
                            end
                            tcc_pkg::CH_LF:
                            begin
                                col_next = '0;
                                if (row_last)
                                begin
                                    row_next  = '0;
                                    base_next = '0;
                                end
                                else
                                begin
                                    row_next  = row_reg + ROW_W'(1);
                                    base_next = add_sum;
                                end
                            end
                            tcc_pkg::CH_FF:
                            begin
                                addr_next  = '0;
                                last_next  = ADDR_W'(tcc_pkg::CELLS - 1);
                                fill_next  = tcc_pkg::BLANK_CELL;
                                row_next   = '0;
                                col_next   = '0;
                                base_next  = '0;
                                state_next = tcc_pkg::S_FILL;
                            end
                            tcc_pkg::CH_CR:
                            begin
                                col_next = '0;
                            end
                            default:
                            begin
                                char_next = req.char_code;
                                if (col_zero)
                                begin
                                    // blank the cursor row before the first cell
                                    addr_next  = base_reg;
                                    last_next  = add_sum;
                                    fill_next  = tcc_pkg::BLANK_CELL;
                                    state_next = tcc_pkg::S_BLANK;
                                end
                                else
                                begin
                                    addr_next  = add_sum;
                                    state_next = tcc_pkg::S_WRITE;
                                end
                            end
                        endcase
                    end
                end
            end

            tcc_pkg::S_FILL:
            begin
                ram_we = 1'b1;
                if (sweep_end)
                begin
                    state_next = tcc_pkg::S_DONE;
                end
                else
                begin
                    addr_next = add_sum;
                end
            end

            tcc_pkg::S_BLANK:
            begin
                ram_we = 1'b1;
                if (sweep_end)
                begin
                    // column 0 cell sits at the row base
                    addr_next  = base_reg;
                    state_next = tcc_pkg::S_WRITE;
                end
                else
                begin
                    addr_next = add_sum;
                end
            end

            tcc_pkg::S_RDWAIT:
            begin
                val_next   = idx_ok_reg ? ram_rdata : '0;
                state_next = tcc_pkg::S_DONE;
            end

            tcc_pkg::S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_wdata = put_cell;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next  = '0;
                        base_next = '0;
                    end
                    else
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        base_next = add_sum;
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
                state_next = tcc_pkg::S_DONE;
            end

            tcc_pkg::S_DONE:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = tcc_pkg::ROW_OUT_W'(row_reg);
                    out_col_next   = tcc_pkg::COL_OUT_W'(col_reg);
                    out_val_next   = val_reg;
                    state_next     = tcc_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tcc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tcc_pkg::S_CLEAR;
            addr_reg        <= '0;
            last_reg        <= ADDR_W'(tcc_pkg::CELLS - 1);
            fill_reg        <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            base_reg        <= '0;
            text_colour_reg <= tcc_pkg::TXT_RESET;
            back_colour_reg <= tcc_pkg::BCK_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            last_reg        <= last_next;
            fill_reg        <= fill_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            base_reg        <= base_next;
            text_colour_reg <= text_colour_next;
            back_colour_reg <= back_colour_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        idx_ok_reg  <= idx_ok_next;
        val_reg     <= val_next;
        out_row_reg <= out_row_next;
        out_col_reg <= out_col_next;
        out_val_reg <= out_val_next;
    end

    // Assertion terms
    assign cursor_ok = (32'(row_reg) < 32'(tcc_pkg::ROWS))
                    && (32'(col_reg) < 32'(tcc_pkg::COLS));
    assign sweep_ok  = (addr_reg <= last_reg) || (state_reg == tcc_pkg::S_WRITE);

    // Assertions
    `TCC_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> (!rsp.valid && !req.ready), "active during reset")
    `TCC_ASSERT(a_cursor_range, cursor_ok, "cursor out of range")
    `TCC_ASSERT(a_idle_no_write, req.ready |-> !ram_we, "cell write while idle")
    `TCC_ASSERT(a_accept_busy, (req.valid && req.ready) |=> !req.ready, "ready after transfer")
    `TCC_ASSERT(a_sweep_bound, ram_we |-> sweep_ok, "sweep past end")

endmodule
